@@ design/xcfp_pkg.sv @@
// Shared types and constants of the XOR-checked frame parser.
package xcfp_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegFirstHeader  = 3'd0;
  localparam logic [2:0] RegSecondHeader = 3'd1;
  localparam logic [2:0] RegLongest      = 3'd2;
  localparam logic [2:0] RegShortest     = 3'd3;
  localparam logic [2:0] RegLampCode     = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [7:0] FirstHeaderRst  = 8'h55;
  localparam logic [7:0] SecondHeaderRst = 8'hAA;
  localparam logic [7:0] LongestRst      = 8'd11;
  localparam logic [7:0] ShortestRst     = 8'd3;
  localparam logic [7:0] LampCodeRst     = 8'h06;

  // Depth of the byte queue between the front and the back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;

  // Parser phase.
  typedef enum logic [2:0] {
    PhHunt  = 3'd0,
    PhHead2 = 3'd1,
    PhLen   = 3'd2,
    PhBody  = 3'd3,
    PhCheck = 3'd4
  } phase_e;

  // Configuration register set.
  typedef struct packed {
    logic [7:0] first_header;
    logic [7:0] second_header;
    logic [7:0] longest_payload;
    logic [7:0] shortest_payload;
    logic [7:0] lamp_function_code;
  } cfg_t;

  // One classified byte as it waits in the queue.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       hit_first;
    logic       hit_second;
    logic       len_ok;
    logic       len_zero;
  } q_item_t;

  // Head of the queue as the back sees it.
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

@@ design/xcfp_front.sv @@
// Front end: takes input beats, classifies each byte and queues it.
module xcfp_front import xcfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       pop_i,
  output q_head_t    head_o
);

  q_item_t            mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]     count_q, count_d;
  logic               push;
  q_item_t            new_item;

  // Classify the byte against the current configuration.
  always_comb begin
    new_item.rx_byte    = rx_byte_i;
    new_item.hit_first  = (rx_byte_i == cfg_i.first_header);
    new_item.hit_second = (rx_byte_i == cfg_i.second_header);
    new_item.len_ok     = (rx_byte_i >= cfg_i.shortest_payload) &&
                          (rx_byte_i <= cfg_i.longest_payload);
    new_item.len_zero   = (rx_byte_i == 8'd0);
  end

  assign in_ready_o = (count_q != (QPtrW+1)'(QDepth));
  assign push       = in_valid_i && in_ready_o;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

@@ design/xcfp_back.sv @@
// Back end: frame state machine, XOR check and the result register.
module xcfp_back import xcfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  q_head_t    head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] function_code_o,
  output logic [7:0] lamp_number_o,
  output logic       lamp_on_o,
  output logic       is_lamp_command_o,
  output logic [7:0] payload_length_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] frame_len_q, frame_len_d;
  logic [7:0] seen_q, seen_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] held_func_q, held_func_d;
  logic [7:0] held_lamp_q, held_lamp_d;
  logic       held_nz_q, held_nz_d;
  logic       out_valid_q;
  logic       emit;
  logic [7:0] b;

  // Take a byte whenever the result register is free or draining.
  assign pop_o = head_i.valid && (!out_valid_q || out_ready_i);
  assign b     = head_i.item.rx_byte;

  // Next state of the parser for the popped byte.
  always_comb begin
    phase_d     = phase_q;
    frame_len_d = frame_len_q;
    seen_d      = seen_q;
    xor_d       = xor_q;
    held_func_d = held_func_q;
    held_lamp_d = held_lamp_q;
    held_nz_d   = held_nz_q;
    emit        = 1'b0;
    if (pop_o) begin
      unique case (phase_q)
        PhHunt: begin
          if (head_i.item.hit_first) begin
            xor_d   = b;
            phase_d = PhHead2;
          end
        end
        PhHead2: begin
          if (head_i.item.hit_second) begin
            xor_d   = xor_q ^ b;
            phase_d = PhLen;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhLen: begin
          if (!head_i.item.len_ok) begin
            phase_d = PhHunt;
          end else begin
            frame_len_d = b;
            seen_d      = '0;
            held_func_d = '0;
            held_lamp_d = '0;
            held_nz_d   = 1'b0;
            xor_d       = xor_q ^ b;
            phase_d     = head_i.item.len_zero ? PhCheck : PhBody;
          end
        end
        PhBody: begin
          if (seen_q == 8'd0) begin
            held_func_d = b;
          end else if (seen_q == 8'd1) begin
            held_lamp_d = b;
          end else if (seen_q == 8'd2) begin
            held_nz_d = (b != 8'd0);
          end
          xor_d  = xor_q ^ b;
          seen_d = seen_q + 8'd1;
          if (seen_d >= frame_len_q) begin
            phase_d = PhCheck;
          end
        end
        PhCheck: begin
          phase_d = PhHunt;
          emit    = (b == xor_q);
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      frame_len_q <= '0;
      seen_q      <= '0;
      xor_q       <= '0;
      held_func_q <= '0;
      held_lamp_q <= '0;
      held_nz_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      frame_len_q <= frame_len_d;
      seen_q      <= seen_d;
      xor_q       <= xor_d;
      held_func_q <= held_func_d;
      held_lamp_q <= held_lamp_d;
      held_nz_q   <= held_nz_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      function_code_o   <= held_func_q;
      lamp_number_o     <= held_lamp_q;
      lamp_on_o         <= held_nz_q;
      is_lamp_command_o <= (held_func_q == cfg_i.lamp_function_code);
      payload_length_o  <= frame_len_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/xor_checked_frame_parser_core.sv @@
// Top level of the XOR-checked frame parser: configuration registers and the two halves.
// Throughput: one byte beat per cycle while the queue has room; the back consumes one
// queued byte each cycle unless a result beat waits unaccepted, which holds the back while the
// queue fills. A result comes from the check byte: it waits in the queue and, as it leaves,
// loads the result register when it matches the running XOR.
// Reset: configuration returns to its default values, the queue empties and the parser hunts.
module xor_checked_frame_parser_core import xcfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] function_code_o,
  output logic [7:0] lamp_number_o,
  output logic       lamp_on_o,
  output logic       is_lamp_command_o,
  output logic [7:0] payload_length_o
);

  cfg_t    cfg_q;
  q_head_t head;
  logic    pop;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_header       <= FirstHeaderRst;
      cfg_q.second_header      <= SecondHeaderRst;
      cfg_q.longest_payload    <= LongestRst;
      cfg_q.shortest_payload   <= ShortestRst;
      cfg_q.lamp_function_code <= LampCodeRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegFirstHeader:  cfg_q.first_header       <= cfg_data_i;
        RegSecondHeader: cfg_q.second_header      <= cfg_data_i;
        RegLongest:      cfg_q.longest_payload    <= cfg_data_i;
        RegShortest:     cfg_q.shortest_payload   <= cfg_data_i;
        RegLampCode:     cfg_q.lamp_function_code <= cfg_data_i;
        default: ;
      endcase
    end
  end

  xcfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  xcfp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .function_code_o   (function_code_o),
    .lamp_number_o     (lamp_number_o),
    .lamp_on_o         (lamp_on_o),
    .is_lamp_command_o (is_lamp_command_o),
    .payload_length_o  (payload_length_o)
  );

endmodule
